>>> design/txr_pkg.sv
`timescale 1ns / 1ps

package txr_pkg;

    localparam int DEPTH_DEF = 64;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_WAIT = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STS_DONE      = 2'd0,
        STS_FULL      = 2'd1,
        STS_TOO_LARGE = 2'd2,
        STS_MUST_WAIT = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_stat;

endpackage

>>> design/tx_ring_with_space_wake.sv
`timescale 1ns / 1ps
// Channel   Handshake                 Beat contents
// input     i_in_valid / o_in_ready   i_action, i_data_byte, i_want_space
// output    o_out_valid / i_out_ready o_tx_valid, o_tx_byte, o_status, o_tx_idle,
//                                     o_wake, o_start_transmit, o_free_count
//
// Each item is captured in the idle state, which also reads the ring memory at the
// read index; the execute state updates the indices, threshold and result register.
// A new item is taken only in the idle state, after the last one has been committed.
// Reset clears the indices, the count and the threshold; ring contents are not cleared.
// A result that waits holds the next captured item in its execute cycle until taken.

module tx_ring_with_space_wake #(
    parameter int DEPTH = txr_pkg::DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_data_byte,
    input  logic signed [8:0] i_want_space,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_tx_valid,
    output logic [7:0]        o_tx_byte,
    output logic [1:0]        o_status,
    output logic              o_tx_idle,
    output logic              o_wake,
    output logic              o_start_transmit,
    output logic [7:0]        o_free_count
);
    import txr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    txr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    txr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_action         (i_action),
        .i_data_byte      (i_data_byte),
        .i_want_space     (i_want_space),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_tx_valid       (o_tx_valid),
        .o_tx_byte        (o_tx_byte),
        .o_status         (o_status),
        .o_tx_idle        (o_tx_idle),
        .o_wake           (o_wake),
        .o_start_transmit (o_start_transmit),
        .o_free_count     (o_free_count)
    );

endmodule

>>> design/txr_ctrl.sv
`timescale 1ns / 1ps

module txr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  txr_pkg::t_stat i_stat,
    output txr_pkg::t_cmd  o_cmd
);
    import txr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_stat.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.commit = !i_stat.out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> design/txr_dp.sv
`timescale 1ns / 1ps

module txr_dp #(
    parameter int DEPTH = txr_pkg::DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  txr_pkg::t_cmd     i_cmd,
    output txr_pkg::t_stat    o_stat,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_data_byte,
    input  logic signed [8:0] i_want_space,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_tx_valid,
    output logic [7:0]        o_tx_byte,
    output logic [1:0]        o_status,
    output logic              o_tx_idle,
    output logic              o_wake,
    output logic              o_start_transmit,
    output logic [7:0]        o_free_count
);
    import txr_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [IW-1:0] MAX_CNT = IW'(DEPTH - 1);
    localparam logic signed [8:0] MAX_WANT = 9'(DEPTH - 1);
    localparam logic [8:0] FREE_TOP = 9'(DEPTH - 1);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    logic [1:0]        r_action;
    logic [7:0]        r_byte;
    logic signed [8:0] r_want;

    logic [IW-1:0]     r_wr, n_wr;
    logic [IW-1:0]     r_rd, n_rd;
    logic [IW-1:0]     r_cnt, n_cnt;
    logic signed [8:0] r_thr, n_thr;

    logic        r_out_valid;
    logic        r_out_tx_valid, n_out_tx_valid;
    logic [7:0]  r_out_tx_byte, n_out_tx_byte;
    t_status     r_out_status, n_out_status;
    logic        r_out_tx_idle, n_out_tx_idle;
    logic        r_out_wake, n_out_wake;
    logic        r_out_start, n_out_start;
    logic [7:0]  r_out_free, n_out_free;

    logic        wr_en;
    logic [8:0]  free_now;
    logic [8:0]  free_after;
    logic        met;

    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx);
        next_slot = (idx == LAST_IDX) ? '0 : idx + IW'(1);
    endfunction

    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_byte   <= i_data_byte;
            r_want   <= i_want_space;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= r_byte;
        end
        r_rd_data <= r_mem[r_rd];
    end

    assign free_now = FREE_TOP - 9'(r_cnt);

    always_comb begin
        n_wr           = r_wr;
        n_rd           = r_rd;
        n_cnt          = r_cnt;
        n_thr          = r_thr;
        wr_en          = 1'b0;
        met            = 1'b1;
        n_out_tx_valid = 1'b0;
        n_out_tx_byte  = '0;
        n_out_status   = STS_DONE;
        n_out_tx_idle  = 1'b0;
        n_out_wake     = 1'b0;
        n_out_start    = 1'b0;
        free_after     = free_now;
        case (t_action'(r_action))
            ACT_PUSH: begin
                if (r_cnt == MAX_CNT) begin
                    n_out_status = STS_FULL;
                    if (r_thr == '0) begin
                        n_thr = 9'sd1;
                    end
                end else begin
                    wr_en       = i_cmd.commit;
                    n_out_start = (r_cnt == '0);
                    n_wr        = next_slot(r_wr);
                    n_cnt       = r_cnt + IW'(1);
                    free_after  = free_now - 9'd1;
                end
            end
            ACT_POP: begin
                if (r_cnt != '0) begin
                    n_out_tx_valid = 1'b1;
                    n_out_tx_byte  = r_rd_data;
                    n_rd           = next_slot(r_rd);
                    n_cnt          = r_cnt - IW'(1);
                    free_after     = free_now + 9'd1;
                end
                if (n_cnt == '0) begin
                    n_out_tx_idle = 1'b1;
                    if (r_thr != '0) begin
                        n_thr      = '0;
                        n_out_wake = 1'b1;
                    end
                end else if (r_thr > 9'sd0 && $signed(free_after) >= r_thr) begin
                    n_thr      = '0;
                    n_out_wake = 1'b1;
                end
            end
            ACT_WAIT: begin
                if (r_want > MAX_WANT) begin
                    n_out_status = STS_TOO_LARGE;
                end else begin
                    if (r_want[8]) begin
                        met = (r_cnt == '0);
                    end else begin
                        met = ($signed(free_now) >= r_want);
                    end
                    if (!met) begin
                        n_out_status = STS_MUST_WAIT;
                        if (r_thr == '0) begin
                            n_thr = r_want;
                        end
                    end
                end
            end
            default: begin
                n_out_status = STS_DONE;
            end
        endcase
        n_out_free = free_after[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr        <= '0;
            r_rd        <= '0;
            r_cnt       <= '0;
            r_thr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_wr        <= n_wr;
                r_rd        <= n_rd;
                r_cnt       <= n_cnt;
                r_thr       <= n_thr;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_tx_valid <= n_out_tx_valid;
            r_out_tx_byte  <= n_out_tx_byte;
            r_out_status   <= n_out_status;
            r_out_tx_idle  <= n_out_tx_idle;
            r_out_wake     <= n_out_wake;
            r_out_start    <= n_out_start;
            r_out_free     <= n_out_free;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_tx_valid       = r_out_tx_valid;
    assign o_tx_byte        = r_out_tx_byte;
    assign o_status         = r_out_status;
    assign o_tx_idle        = r_out_tx_idle;
    assign o_wake           = r_out_wake;
    assign o_start_transmit = r_out_start;
    assign o_free_count     = r_out_free;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_CNT)
        else $error("Ring count exceeds capacity.");

    a_empty_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd))
        else $error("Empty ring with unequal indices.");

    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !(r_out_valid && !i_out_ready))
        else $error("Result committed over a waiting beat.");

    a_wake_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_wake) |-> (r_thr == '0))
        else $error("Threshold still armed after wake.");

endmodule
